// ===== rtl/presence_qualifier_with_lockout_macros.svh =====
// Assertion macros for the presence qualifier with lockout.
`ifndef PRESENCE_QUALIFIER_WITH_LOCKOUT_MACROS_SVH
`define PRESENCE_QUALIFIER_WITH_LOCKOUT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PQLO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PQLO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pqlo_pkg.sv =====
// Shared types and constants for the presence qualifier with lockout.
package pqlo_pkg;

   // Width of timestamps and of the millisecond registers
   localparam int TIME_WIDTH  = 32;
   localparam int LIMIT_WIDTH = 8;
   localparam int CSR_IDX_WIDTH = 2;

   // Register reset values
   localparam logic [LIMIT_WIDTH-1:0] FRAME_LIMIT_RST  = LIMIT_WIDTH'(10);
   localparam logic [TIME_WIDTH-1:0]  MAX_EVENT_RST    = TIME_WIDTH'(180000);
   localparam logic [TIME_WIDTH-1:0]  LOCKOUT_RST      = TIME_WIDTH'(10000);

   // Register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FRAME_LIMIT = 2'd0,
      CSR_MAX_EVENT   = 2'd1,
      CSR_LOCKOUT     = 2'd2
   } csr_idx_type;

   // Live configuration
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] frame_limit;
      logic [TIME_WIDTH-1:0]  max_event_ms;
      logic [TIME_WIDTH-1:0]  lockout_ms;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic blocked;
      logic event_res;
   } step_res_type;

endpackage

// ===== rtl/pqlo_csr.sv =====
// Configuration registers of the presence qualifier with lockout.
module pqlo_csr
   import pqlo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]    csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take writes; unknown indexes are dropped
   assign csr_ready = 1'b1;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FRAME_LIMIT: cfg_in.frame_limit  = csr_data[LIMIT_WIDTH-1:0];
            CSR_MAX_EVENT:   cfg_in.max_event_ms = csr_data;
            CSR_LOCKOUT:     cfg_in.lockout_ms   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_limit  <= FRAME_LIMIT_RST;
         cfg_ff.max_event_ms <= MAX_EVENT_RST;
         cfg_ff.lockout_ms   <= LOCKOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/pqlo_step.sv =====
// Per-frame debounce counter, event timer and lockout state.
module pqlo_step
   import pqlo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  detected,
   input  logic [TIME_WIDTH-1:0] time_ms,
   input  cfg_type               cfg,
   output step_res_type          res
);

   logic [LIMIT_WIDTH-1:0] count_ff, count_in;
   logic                   timing_ff, timing_in;
   logic [TIME_WIDTH-1:0]  ev_start_ff, ev_start_in;
   logic                   lock_ff, lock_in;
   logic [TIME_WIDTH-1:0]  lock_start_ff, lock_start_in;

   logic [TIME_WIDTH-1:0]  lock_elapsed;
   logic                   lock_hold;
   logic                   timing_live;
   logic [LIMIT_WIDTH:0]   count_up;
   logic [LIMIT_WIDTH:0]   half_sum;
   logic [LIMIT_WIDTH-1:0] threshold;
   logic [LIMIT_WIDTH-1:0] count_new;
   logic                   over;
   logic [TIME_WIDTH-1:0]  ev_start_eff;
   logic [TIME_WIDTH-1:0]  ev_elapsed;
   logic                   trip;

   // Lockout still running; differences wrap modulo the time width
   assign lock_elapsed = time_ms - lock_start_ff;
   assign lock_hold    = lock_ff && (lock_elapsed < cfg.lockout_ms);
   // An expiring lockout clears the event timer
   assign timing_live  = timing_ff && !lock_ff;

   // Saturating counter
   assign count_up = {1'b0, count_ff} + (LIMIT_WIDTH+1)'(1);
   always_comb begin
      if (detected) begin
         count_new = (count_up < {1'b0, cfg.frame_limit}) ?
                     count_up[LIMIT_WIDTH-1:0] : cfg.frame_limit;
      end else if (count_ff != '0) begin
         count_new = count_ff - LIMIT_WIDTH'(1);
      end else begin
         count_new = '0;
      end
   end

   // Threshold is half the limit, rounded up
   assign half_sum  = ({1'b0, cfg.frame_limit} + (LIMIT_WIDTH+1)'(1)) >> 1;
   assign threshold = half_sum[LIMIT_WIDTH-1:0];
   assign over      = (count_new >= threshold);

   // Continuous event time
   assign ev_start_eff = timing_live ? ev_start_ff : time_ms;
   assign ev_elapsed   = time_ms - ev_start_eff;
   assign trip         = over && (ev_elapsed >= cfg.max_event_ms);

   // Next state and result
   always_comb begin
      count_in      = count_ff;
      timing_in     = timing_ff;
      ev_start_in   = ev_start_ff;
      lock_in       = lock_ff;
      lock_start_in = lock_start_ff;
      if (lock_hold) begin
         res.event_res = 1'b0;
         res.blocked   = 1'b1;
      end else begin
         res.event_res = over && !trip;
         res.blocked   = trip;
         if (fire) begin
            count_in  = count_new;
            timing_in = over && !trip;
            lock_in   = trip;
            if (over && !timing_live) begin
               ev_start_in = time_ms;
            end
            if (trip) begin
               lock_start_in = time_ms;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         timing_ff     <= 1'b0;
         ev_start_ff   <= '0;
         lock_ff       <= 1'b0;
         lock_start_ff <= '0;
      end else begin
         count_ff      <= count_in;
         timing_ff     <= timing_in;
         ev_start_ff   <= ev_start_in;
         lock_ff       <= lock_in;
         lock_start_ff <= lock_start_in;
      end
   end

endmodule

// ===== rtl/presence_qualifier_with_lockout.sv =====
// Top level of the presence qualifier with lockout: handshake stages and assembly.
//
//   channel  direction  payload
//   req      in         tdata[0] detected, tdata[32:1] time_ms
//   rsp      out        tdata[0] event_res, tdata[1] blocked
//   csr      in         csr_index register, csr_data value
//
// One frame per cycle while the response is not stalled: a frame enters the input
// register, and the debounce and timer logic writes its result into the output register.
// Reset is synchronous and clears the counter, timers and lockout. A stalled
// response holds one result while one more frame waits in the input register.
module presence_qualifier_with_lockout
   import pqlo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [39:0]              req_tdata,  // detected, time_ms, zero pad
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,  // event_res, blocked, zero pad
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]    csr_data
);

   `include "presence_qualifier_with_lockout_macros.svh"

   cfg_type               cfg;
   step_res_type          res;
   logic                  in_valid_ff, in_valid_in;
   logic                  in_det_ff;
   logic [TIME_WIDTH-1:0] in_time_ff;
   logic                  out_valid_ff, out_valid_in;
   step_res_type          out_res_ff;
   logic                  advance;
   logic                  req_fire;

   // Move a frame from the input register to the output register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   pqlo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pqlo_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .detected (in_det_ff),
      .time_ms  (in_time_ff),
      .cfg      (cfg),
      .res      (res)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_det_ff  <= req_tdata[0];
         in_time_ff <= req_tdata[TIME_WIDTH:1];
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_res_ff.blocked, out_res_ff.event_res};

   // A qualified event never coincides with a lockout
   `PQLO_ASSERT_NOW(a_event_not_blocked, out_valid_ff, !(out_res_ff.event_res && out_res_ff.blocked), "event and blocked both set")
   // Every processed frame lands in the output register
   `PQLO_ASSERT_NEXT(a_advance_fills, advance, out_valid_ff, "processed frame lost")
   // A waiting frame stays while the response is stalled
   `PQLO_ASSERT_NEXT(a_hold_input, in_valid_ff && out_valid_ff && !rsp_tready, in_valid_ff, "waiting frame dropped")

endmodule
